// ===== rtl/core/negative_constraint_table_defines.svh =====
// Assertion macros shared by the negative-constraint table RTL.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef NEGATIVE_CONSTRAINT_TABLE_DEFINES_SVH
`define NEGATIVE_CONSTRAINT_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/nct_pkg.sv =====
// Package for the negative-constraint table: item mode codes, the control
// state type and the fixed field widths. No dependencies.
`default_nettype none

package nct_pkg;

    // Item mode codes.
    localparam logic [1:0] MODE_ADD_VERTEX = 2'd0;
    localparam logic [1:0] MODE_ADD_EDGE   = 2'd1;
    localparam logic [1:0] MODE_CHECK      = 2'd2;
    localparam logic [1:0] MODE_LATEST     = 2'd3;

    // Fixed widths of the interface fields.
    localparam int AGENT_W  = 6;
    localparam int LATEST_W = 10;

    // Control states of the top level.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RESOLVE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/nct_cell.sv =====
// One cell of the ban chain: holds a single ban entry and its valid bit,
// compares it with the broadcast key and passes its entry on when the chain shifts.
`default_nettype none

module nct_cell #(
    parameter int COORD_BITS = 8,
    parameter int KEY_W      = 48,
    parameter int ENTRY_W    = 49
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift_en,
    input  wire logic [ENTRY_W-1:0] entry_in,
    input  wire logic               valid_in,
    output logic      [ENTRY_W-1:0] entry_out,
    output logic                    valid_out,
    input  wire logic               cmp_en,
    input  wire logic [KEY_W-1:0]   key,
    output logic                    hit_vertex,
    output logic                    hit_edge
);

    localparam int CELL_W = 2 * COORD_BITS;
    localparam int FROM_W = 4 * COORD_BITS;

    logic [ENTRY_W-1:0] entry_reg;
    logic               valid_reg;
    logic               hit_vertex_reg;
    logic               hit_edge_reg;
    logic               same_head;
    logic               same_to;
    logic               same_from;
    logic               is_edge;

    // Field comparisons against the key; a vertex ban ignores the from cell.
    always_comb
    begin
        is_edge   = entry_reg[ENTRY_W-1];
        same_head = (entry_reg[KEY_W-1:FROM_W] == key[KEY_W-1:FROM_W]);
        same_to   = (entry_reg[CELL_W-1:0] == key[CELL_W-1:0]);
        same_from = (entry_reg[FROM_W-1:CELL_W] == key[FROM_W-1:CELL_W]);
    end

    // Entry storage: the valid bit is control state, the entry itself is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= entry_in;
        end
    end

    // Registered compare results, taken when an item is transferred in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_vertex_reg <= 1'b0;
            hit_edge_reg   <= 1'b0;
        end
        else if (cmp_en)
        begin
            hit_vertex_reg <= valid_reg && !is_edge && same_head && same_to;
            hit_edge_reg   <= valid_reg && is_edge && same_head && same_to && same_from;
        end
    end

    assign entry_out  = entry_reg;
    assign valid_out  = valid_reg;
    assign hit_vertex = hit_vertex_reg;
    assign hit_edge   = hit_edge_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nct_goal_store.sv =====
// Per-agent goal-ban step memory with a clearing pass after reset.
// Single write port, one registered read port. No package dependencies.
`default_nettype none

module nct_goal_store #(
    parameter int AGENT_COUNT = 64,
    parameter int STEP_BITS   = 10,
    parameter int ADDR_W      = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output logic      [STEP_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire logic [STEP_BITS-1:0] wr_data,
    output logic                      busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(AGENT_COUNT - 1);

    logic [STEP_BITS-1:0] mem [AGENT_COUNT];
    logic [STEP_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    clr_addr_next;
    logic                 busy_reg;
    logic                 busy_next;

    // Sweep counter for the clearing pass.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // Memory write: zeros during the clearing pass, otherwise the update port.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

// ===== rtl/core/negative_constraint_table.sv =====
// Negative-constraint table: a chain of ban cells plus a per-agent goal-ban store.
// Flow: the cells register their compare results on the input transfer (compare), then
// the resolve state loads the output register once out_ready allows it (resolve). A new
// item is taken only after the last one is resolved. Reset: the chain empties at once;
// the goal-ban store then clears all AGENT_COUNT entries, during which in_ready stays low.
`default_nettype none

`include "negative_constraint_table_defines.svh"

module negative_constraint_table #(
    parameter int TABLE_ENTRIES = 256,
    parameter int AGENT_COUNT   = 64,
    parameter int COORD_BITS    = 8,
    parameter int STEP_BITS     = 10
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] mode,
    input  wire logic [5:0] agent_id,
    input  wire logic [9:0] time_step,
    input  wire logic [7:0] from_row,
    input  wire logic [7:0] from_col,
    input  wire logic [7:0] to_row,
    input  wire logic [7:0] to_col,
    input  wire logic [7:0] goal_row,
    input  wire logic [7:0] goal_col,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            move_allowed,
    output logic [9:0]      latest_step,
    output logic            entry_added,
    output logic            table_full
);

    localparam int CELL_W  = 2 * COORD_BITS;
    localparam int FROM_W  = 4 * COORD_BITS;
    localparam int KEY_W   = nct_pkg::AGENT_W + STEP_BITS + FROM_W;
    localparam int ENTRY_W = KEY_W + 1;
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W  = $clog2(AGENT_COUNT);

    // Control and item registers.
    nct_pkg::state_t        state_reg;
    nct_pkg::state_t        state_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic [1:0]             mode_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [CELL_W-1:0]      goal_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   allowed_reg;
    logic                   allowed_next;
    logic [nct_pkg::LATEST_W-1:0] latest_reg;
    logic [nct_pkg::LATEST_W-1:0] latest_next;
    logic                   added_reg;
    logic                   added_next;
    logic                   full_reg;
    logic                   full_next;

    // Chain wiring and resolve signals.
    logic                   accept;
    logic                   load_out;
    logic                   insert_en;
    logic                   goal_wr_en;
    logic                   clr_busy;
    logic [KEY_W-1:0]       key_in;
    logic [ENTRY_W-1:0]     new_entry;
    logic [ENTRY_W-1:0]     chain_entry [TABLE_ENTRIES];
    logic                   chain_valid [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hit_vertex_vec;
    logic [TABLE_ENTRIES-1:0] hit_edge_vec;
    logic                   any_vertex;
    logic                   any_edge;
    logic                   is_dup;
    logic                   is_full;
    logic                   agent_ok;
    logic [nct_pkg::AGENT_W-1:0] agent_q;
    logic [STEP_BITS-1:0]   step_q;
    logic [STEP_BITS-1:0]   goal_rd;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == nct_pkg::ST_IDLE) && !clr_busy;

    // Key as seen by the cells: agent, step, from cell, to cell.
    assign key_in = {agent_id, STEP_BITS'(time_step),
                     COORD_BITS'(from_row), COORD_BITS'(from_col),
                     COORD_BITS'(to_row), COORD_BITS'(to_col)};

    // Item registers, loaded on the input transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            key_reg  <= key_in;
            goal_reg <= {COORD_BITS'(goal_row), COORD_BITS'(goal_col)};
        end
    end

    assign agent_q   = key_reg[KEY_W-1 -: nct_pkg::AGENT_W];
    assign step_q    = key_reg[FROM_W +: STEP_BITS];
    assign agent_ok  = (32'(agent_q) < AGENT_COUNT);
    assign new_entry = {(mode_reg == nct_pkg::MODE_ADD_EDGE), key_reg};

    // The cell chain: a new ban enters at cell 0 and every entry moves one cell on.
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            logic [ENTRY_W-1:0] left_entry;
            logic               left_valid;

            if (gi == 0)
            begin : g_head
                assign left_entry = new_entry;
                assign left_valid = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = chain_entry[gi-1];
                assign left_valid = chain_valid[gi-1];
            end

            nct_cell #(
                .COORD_BITS (COORD_BITS),
                .KEY_W      (KEY_W),
                .ENTRY_W    (ENTRY_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (insert_en),
                .entry_in   (left_entry),
                .valid_in   (left_valid),
                .entry_out  (chain_entry[gi]),
                .valid_out  (chain_valid[gi]),
                .cmp_en     (accept),
                .key        (key_in),
                .hit_vertex (hit_vertex_vec[gi]),
                .hit_edge   (hit_edge_vec[gi])
            );
        end
    endgenerate

    // Goal-ban store: read on the input transfer, written back on resolve.
    nct_goal_store #(
        .AGENT_COUNT (AGENT_COUNT),
        .STEP_BITS   (STEP_BITS),
        .ADDR_W      (ADDR_W)
    ) u_goal_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(agent_id)),
        .rd_data (goal_rd),
        .wr_en   (goal_wr_en),
        .wr_addr (ADDR_W'(agent_q)),
        .wr_data (step_q),
        .busy    (clr_busy)
    );

    // Resolve: reduce the hit bits, decide the insert and form the result.
    always_comb
    begin
        any_vertex     = |hit_vertex_vec;
        any_edge       = |hit_edge_vec;
        is_full        = (count_reg == COUNT_W'(TABLE_ENTRIES));
        is_dup         = (mode_reg == nct_pkg::MODE_ADD_VERTEX) ? any_vertex : any_edge;
        load_out       = (state_reg == nct_pkg::ST_RESOLVE) && (!out_valid_reg || out_ready);
        state_next     = state_reg;
        count_next     = count_reg;
        insert_en      = 1'b0;
        goal_wr_en     = 1'b0;
        allowed_next   = 1'b0;
        latest_next    = '0;
        added_next     = 1'b0;
        full_next      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (mode_reg)
            nct_pkg::MODE_ADD_VERTEX,
            nct_pkg::MODE_ADD_EDGE:
            begin
                added_next = !is_dup && !is_full;
                full_next  = !is_dup && is_full;
            end
            nct_pkg::MODE_CHECK:
            begin
                allowed_next = !any_vertex && !any_edge;
            end
            nct_pkg::MODE_LATEST:
            begin
                latest_next = agent_ok ? nct_pkg::LATEST_W'(goal_rd) : '0;
            end
            default:
            begin
                allowed_next = 1'b0;
            end
        endcase

        case (state_reg)
            nct_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = nct_pkg::ST_RESOLVE;
                end
            end
            nct_pkg::ST_RESOLVE:
            begin
                if (load_out)
                begin
                    state_next     = nct_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                    insert_en      = added_next;
                    if (added_next)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    goal_wr_en = (mode_reg == nct_pkg::MODE_ADD_VERTEX) && agent_ok &&
                                 (key_reg[CELL_W-1:0] == goal_reg) && (step_q > goal_rd);
                end
            end
            default:
            begin
                state_next = nct_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nct_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register, loaded when the resolved result can be handed over.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            allowed_reg <= allowed_next;
            latest_reg  <= latest_next;
            added_reg   <= added_next;
            full_reg    <= full_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign move_allowed = allowed_reg;
    assign latest_step  = latest_reg;
    assign entry_added  = added_reg;
    assign table_full   = full_reg;

    // Checks on the control logic.
    `NCT_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_reg) <= TABLE_ENTRIES, "entry count overflow")
    `NCT_ASSERT_NEXT(a_insert_counts, insert_en, count_reg == $past(count_reg) + 1'b1, "insert lost")
    `NCT_ASSERT_NOW(a_resolve_origin, state_reg == nct_pkg::ST_RESOLVE,
        $past(accept) || $past(state_reg == nct_pkg::ST_RESOLVE), "resolve without item")
    `NCT_ASSERT_NOW(a_result_origin, $rose(out_valid_reg),
        $past(state_reg == nct_pkg::ST_RESOLVE), "result without resolve")
    `NCT_ASSERT_NOW(a_no_item_in_clear, clr_busy, state_reg == nct_pkg::ST_IDLE,
        "item taken during clearing pass")

endmodule

`default_nettype wire
